### hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);

// Clocked assertion, also checked during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

### hdl/nphsl_pkg.sv
// Types and constants of the nearest palette color block.
package nphsl_pkg;

  localparam int VAL_W      = 17;
  localparam int DIVIDEND_W = 25;
  localparam int DIVISOR_W  = 9;
  localparam int QUOT_W     = 18;
  localparam int DIST_W     = 51;
  localparam int PAIR_COUNT = 8;
  localparam int PAIR_W     = 48;
  localparam int INDEX_W    = 4;

  localparam logic [DIST_W-1:0]    START_DIST = DIST_W'(65025) << 32;
  localparam logic [DIVISOR_W-1:0] L_DIVISOR  = 9'd510;
  localparam logic [DIVIDEND_W-1:0] HUE_SCALE = 25'd15360;

  localparam logic [PAIR_W-1:0] PAIR_RESET [PAIR_COUNT] = '{
    48'd2818572288, 48'd724373121024, 48'd184720783048704, 48'd185442337575936,
    48'd92724037702740, 48'd93458477154132, 48'd280740537259092,
    48'd281474976710484
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SQUARE,
    ST_COMPARE,
    ST_OUTPUT
  } state_t;

  typedef enum logic [1:0] {
    PH_L,
    PH_S,
    PH_H
  } phase_t;

endpackage

### hdl/nphsl_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
`include "assert_macros.svh"

module nphsl_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [nphsl_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [nphsl_pkg::DIVISOR_W-1:0]    divisor,
  output logic                               done,
  output logic [nphsl_pkg::QUOT_W-1:0]       quotient
);
  import nphsl_pkg::*;

  localparam int STEPS = QUOT_W / 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [QUOT_W-1:0]    low;
  logic [DIVISOR_W:0]   t1, t2;
  logic [DIVISOR_W-1:0] r1, r2;
  logic                 b1, b2;

  always_comb begin
    t1 = {rem, low[QUOT_W-1]};
    b1 = t1 >= {1'b0, divisor};
    r1 = b1 ? DIVISOR_W'(t1 - {1'b0, divisor}) : t1[DIVISOR_W-1:0];
    t2 = {r1, low[QUOT_W-2]};
    b2 = t2 >= {1'b0, divisor};
    r2 = b2 ? DIVISOR_W'(t2 - {1'b0, divisor}) : t2[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUOT_W]);
        low      <= dividend[QUOT_W-1:0];
        quotient <= '0;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= r2;
        low      <= {low[QUOT_W-3:0], 2'b00};
        quotient <= {quotient[QUOT_W-3:0], b1, b2};
        cnt      <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `ASSERT_CLK(a_start_idle, clk, rst, start |-> !busy, "divider started while busy")
  `ASSERT_CLK(a_done_ends, clk, rst, done |-> !busy, "divider done while still busy")

endmodule

### hdl/nearest_palette_color_hsl.sv
// Nearest palette color by HSL distance: top level with sequencer and datapath.
// Each request converts the sample and then every palette entry to HSL through one
// shared divider that yields two quotient bits a cycle (three divisions per color,
// one for grays), so 1 + PALETTE_SIZE colors are converted per request. Each entry
// then takes four steps on one squaring multiplier and a compare. Per entry the
// sequencer runs load, the divisions, squaring and compare; an output state and a
// return to idle close the request. in_ready is high only while no request is in
// progress; a finished index waits in the output register while the next request
// is taken.
`include "assert_macros.svh"

module nearest_palette_color_hsl #(
  parameter int PALETTE_SIZE = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [nphsl_pkg::INDEX_W-1:0]      color_index,
  input  logic                               write_enable,
  input  logic [3:0]                         write_index,
  input  logic [nphsl_pkg::PAIR_W-1:0]       write_data
);
  import nphsl_pkg::*;

  localparam int N_SEARCH = (PALETTE_SIZE > 16) ? 16 : PALETTE_SIZE;
  localparam int SLOT_W   = $clog2(N_SEARCH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(N_SEARCH);

  state_t state, state_next;
  phase_t phase;

  logic [PAIR_W-1:0] pal [PAIR_COUNT];
  logic [SLOT_W-1:0] slot;
  logic [3:0]        entry_idx;
  logic [23:0]       entry_rgb;
  logic [7:0]        cur_r, cur_g, cur_b;
  logic [VAL_W-1:0]  c_h, c_s, c_l, p_h, p_s, p_l;
  logic [DIST_W-1:0] best, acc;
  logic [INDEX_W-1:0] pick;
  logic [1:0]        sq_cnt;
  logic [33:0]       prod;

  logic [7:0]        mx, mn, d;
  logic [8:0]        sum, den;
  logic signed [11:0] k;
  logic [DIVIDEND_W-1:0] hue_num;
  logic              div_start, div_done;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [QUOT_W-1:0]     div_q;
  logic [VAL_W-1:0]      q;
  logic signed [17:0] dh, ds, dl, sq_op;
  logic signed [35:0] sq_full;
  logic               conv_end, out_free;

  assign entry_idx = 4'(slot - SLOT_W'(1));
  assign entry_rgb = entry_idx[0] ? pal[entry_idx[3:1]][47:24] : pal[entry_idx[3:1]][23:0];

  always_comb begin
    mx = cur_r;
    mn = cur_r;
    if (cur_g > mx) mx = cur_g;
    if (cur_b > mx) mx = cur_b;
    if (cur_g < mn) mn = cur_g;
    if (cur_b < mn) mn = cur_b;
    sum = {1'b0, mx} + {1'b0, mn};
    d   = mx - mn;
    den = (sum < 9'd255) ? sum : 9'(10'd510 - {1'b0, sum});
    if (cur_r == mx) begin
      k = $signed({4'b0, cur_g}) - $signed({4'b0, cur_b});
      if (k < 0) k = k + $signed(12'(6 * d));
    end else if (cur_g == mx) begin
      k = $signed({4'b0, cur_b}) - $signed({4'b0, cur_r}) + $signed(12'(2 * d));
    end else begin
      k = $signed({4'b0, cur_r}) - $signed({4'b0, cur_g}) + $signed(12'(4 * d));
    end
    hue_num = DIVIDEND_W'(DIVIDEND_W'(k[10:0]) * HUE_SCALE);
  end

  always_comb begin
    case (phase)
      PH_L: begin
        div_dividend = {sum, 16'h0};
        div_divisor  = L_DIVISOR;
      end
      PH_S: begin
        div_dividend = {1'b0, d, 16'h0};
        div_divisor  = den;
      end
      PH_H: begin
        div_dividend = hue_num;
        div_divisor  = {1'b0, d};
      end
      default: begin
        div_dividend = '0;
        div_divisor  = L_DIVISOR;
      end
    endcase
  end

  assign div_start = (state == ST_DIV_START);
  assign q = div_q[VAL_W-1:0];

  nphsl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign dh = $signed({1'b0, c_h}) - $signed({1'b0, p_h});
  assign ds = $signed({1'b0, c_s}) - $signed({1'b0, p_s});
  assign dl = $signed({1'b0, c_l}) - $signed({1'b0, p_l});

  always_comb begin
    case (sq_cnt)
      2'd0:    sq_op = dh;
      2'd1:    sq_op = ds;
      default: sq_op = dl;
    endcase
  end

  assign sq_full  = sq_op * sq_op;
  assign conv_end = div_done && (phase == PH_H || (phase == PH_L && mx == mn));
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_DIV_START;
      ST_LOAD:      state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (!conv_end) state_next = ST_DIV_START;
          else if (slot == '0) state_next = ST_LOAD;
          else state_next = ST_SQUARE;
        end
      end
      ST_SQUARE:    if (sq_cnt == 2'd3) state_next = ST_COMPARE;
      ST_COMPARE:   state_next = (slot == LAST_SLOT) ? ST_OUTPUT : ST_LOAD;
      ST_OUTPUT:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < PAIR_COUNT; i++) pal[i] <= PAIR_RESET[i];
    end else begin
      state <= state_next;
      if (write_enable && write_index < 4'(PAIR_COUNT)) pal[write_index[2:0]] <= write_data;
      if (state == ST_OUTPUT && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_r <= red;
        cur_g <= green;
        cur_b <= blue;
        slot  <= '0;
        best  <= START_DIST;
        pick  <= '0;
        phase <= PH_L;
      end
      ST_LOAD: begin
        cur_r <= entry_rgb[23:16];
        cur_g <= entry_rgb[15:8];
        cur_b <= entry_rgb[7:0];
        phase <= PH_L;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (phase)
            PH_L: begin
              if (slot == '0) c_l <= q;
              else p_l <= q;
              if (mx == mn) begin
                if (slot == '0) begin
                  c_s <= '0;
                  c_h <= '0;
                end else begin
                  p_s <= '0;
                  p_h <= '0;
                end
              end
              phase <= PH_S;
            end
            PH_S: begin
              if (slot == '0) c_s <= q;
              else p_s <= q;
              phase <= PH_H;
            end
            default: begin
              if (slot == '0) c_h <= q;
              else p_h <= q;
              phase <= PH_L;
            end
          endcase
          if (conv_end && slot == '0) slot <= SLOT_W'(1);
          sq_cnt <= '0;
          acc    <= '0;
        end
      end
      ST_SQUARE: begin
        prod   <= sq_full[33:0];
        sq_cnt <= sq_cnt + 1'b1;
        if (sq_cnt == 2'd1) acc <= acc + DIST_W'({prod, 16'h0});
        else if (sq_cnt != 2'd0) acc <= acc + DIST_W'(prod);
      end
      ST_COMPARE: begin
        if (acc < best) begin
          best <= acc;
          pick <= entry_idx;
        end
        if (slot != LAST_SLOT) slot <= slot + 1'b1;
      end
      ST_OUTPUT: begin
        if (out_free) color_index <= pick;
      end
      default: ;
    endcase
  end

  `ASSERT_CLK(a_done_in_wait, clk, rst, div_done |-> state == ST_DIV_WAIT,
              "divider result outside wait state")
  `ASSERT_CLK(a_search_init, clk, rst, (in_valid && in_ready) |=> (best == START_DIST && pick == '0),
              "search not initialized on request")
  `ASSERT_CLK(a_slot_range, clk, rst, slot <= LAST_SLOT || state == ST_IDLE,
              "palette slot out of range")

endmodule
